>>> rtl/stream_find_replace_defines.svh
// Assertion macros shared by the stream find-and-replace RTL.
`ifndef STREAM_FIND_REPLACE_DEFINES_SVH
`define STREAM_FIND_REPLACE_DEFINES_SVH

`ifndef SYNTHESIS
`define SFR_ASSERT_CLK(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define SFR_ASSERT(label, prop, msg) `SFR_ASSERT_CLK(label, clk, rst_n, prop, msg)
`else
`define SFR_ASSERT_CLK(label, clk_s, rst_s, prop, msg)
`define SFR_ASSERT(label, prop, msg)
`endif

`endif

>>> rtl/sfr_pkg.sv
// Types and constants shared by the stream find-and-replace block.
package sfr_pkg;

  localparam int MaxPattern = 8;
  localparam int MaxValue   = 8;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 4;
  localparam int WORD_W     = 64;
  localparam int CFG_AW     = 5;
  localparam int QDepth     = 2;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int QCntW      = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_VALUE_BYTES    = 2'd2,
    REG_VALUE_LENGTH   = 2'd3
  } sfr_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0] pattern;
    logic [LEN_W-1:0]  plen;
    logic [WORD_W-1:0] value;
    logic [LEN_W-1:0]  vlen;
    logic              clear;
  } sfr_cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] bytes;
    logic [LEN_W-1:0]  count;
    logic              last;
  } sfr_cmd_t;

endpackage

>>> rtl/sfr_in_if.sv
// Input channel interface: one text byte per transaction.
interface sfr_in_if;
  logic                      valid;
  logic                      ready;
  logic [sfr_pkg::BYTE_W-1:0] in_byte;
  logic                      in_last;

  modport source(output valid, in_byte, in_last, input ready);
  modport sink(input valid, in_byte, in_last, output ready);
endinterface

>>> rtl/sfr_out_if.sv
// Result channel interface: one result byte or end marker per transaction.
interface sfr_out_if;
  logic                      valid;
  logic                      ready;
  logic [sfr_pkg::BYTE_W-1:0] out_byte;
  logic                      byte_valid;
  logic                      run_last;
  logic                      stream_end;

  modport source(output valid, out_byte, byte_valid, run_last, stream_end, input ready);
  modport sink(input valid, out_byte, byte_valid, run_last, stream_end, output ready);
endinterface

>>> rtl/sfr_regs.sv
// APB configuration registers with clamped effective lengths.
module sfr_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfr_pkg::CFG_AW-1:0] paddr,
  input  logic [sfr_pkg::WORD_W-1:0] pwdata,
  output logic [sfr_pkg::WORD_W-1:0] prdata,
  output logic                       pready,
  output sfr_pkg::sfr_cfg_t          cfg
);
  import sfr_pkg::*;

  logic [WORD_W-1:0] pattern_r;
  logic [LEN_W-1:0]  plen_r;
  logic [WORD_W-1:0] value_r;
  logic [LEN_W-1:0]  vlen_r;
  logic              wr;
  sfr_reg_t          idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = sfr_reg_t'(paddr[CFG_AW-1:CFG_AW-2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      plen_r    <= '0;
      value_r   <= '0;
      vlen_r    <= '0;
    end else if (wr) begin
      case (idx)
        REG_PATTERN_BYTES:  pattern_r <= pwdata;
        REG_PATTERN_LENGTH: plen_r    <= pwdata[LEN_W-1:0];
        REG_VALUE_BYTES:    value_r   <= pwdata;
        REG_VALUE_LENGTH:   vlen_r    <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PATTERN_BYTES:  prdata = pattern_r;
      REG_PATTERN_LENGTH: prdata = {{(WORD_W-LEN_W){1'b0}}, plen_r};
      REG_VALUE_BYTES:    prdata = value_r;
      REG_VALUE_LENGTH:   prdata = {{(WORD_W-LEN_W){1'b0}}, vlen_r};
      default:            prdata = '0;
    endcase
  end

  assign cfg.pattern = pattern_r;
  assign cfg.plen    = (plen_r > LEN_W'(MaxPattern)) ? LEN_W'(MaxPattern) : plen_r;
  assign cfg.value   = value_r;
  assign cfg.vlen    = (vlen_r > LEN_W'(MaxValue)) ? LEN_W'(MaxValue) : vlen_r;
  assign cfg.clear   = wr && (idx == REG_PATTERN_LENGTH);

endmodule

>>> rtl/sfr_front.sv
// Front end: pending window, pattern compare and emit-command generation.
`include "stream_find_replace_defines.svh"
module sfr_front (
  input  logic              clk,
  input  logic              rst_n,
  sfr_in_if.sink            in_if,
  input  sfr_pkg::sfr_cfg_t cfg,
  input  logic              q_full,
  output logic              cmd_push,
  output sfr_pkg::sfr_cmd_t cmd
);
  import sfr_pkg::*;

  logic [BYTE_W-1:0] win_r   [MaxPattern];
  logic [BYTE_W-1:0] win_nxt [MaxPattern];
  logic [BYTE_W-1:0] tmp     [MaxPattern];
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  cnt_ins, cnt_new;
  logic [WORD_W-1:0] tmp_word;
  logic              full_win, hit, acc;

  assign in_if.ready = !q_full;
  assign acc         = in_if.valid && in_if.ready;

  always_comb begin
    cnt_ins = (cfg.plen == '0 || cnt_r >= cfg.plen) ? '0 : cnt_r;
    cnt_new = cnt_ins + LEN_W'(1);
    for (int k = 0; k < MaxPattern; k++) begin
      tmp[k] = (LEN_W'(k) == cnt_ins) ? in_if.in_byte : win_r[k];
      tmp_word[BYTE_W*k +: BYTE_W] = tmp[k];
    end
    full_win = (cfg.plen != '0) && (cnt_new == cfg.plen);
    hit      = full_win;
    for (int k = 0; k < MaxPattern; k++) begin
      if (LEN_W'(k) < cfg.plen && tmp[k] != cfg.pattern[BYTE_W*k +: BYTE_W]) hit = 1'b0;
    end
  end

  always_comb begin
    cmd.bytes = hit ? cfg.value : tmp_word;
    cmd.last  = in_if.in_last;
    if (cfg.plen == '0) begin
      cmd.count = LEN_W'(1);
    end else if (hit) begin
      cmd.count = cfg.vlen;
    end else if (in_if.in_last) begin
      cmd.count = cnt_new;
    end else if (full_win) begin
      cmd.count = LEN_W'(1);
    end else begin
      cmd.count = '0;
    end
    cmd_push = acc && (cmd.count != '0 || in_if.in_last);
  end

  always_comb begin
    for (int k = 0; k < MaxPattern; k++) begin
      win_nxt[k] = tmp[k];
    end
    if (cfg.plen == '0 || hit || in_if.in_last) begin
      cnt_nxt = '0;
    end else if (full_win) begin
      for (int k = 0; k < MaxPattern - 1; k++) begin
        win_nxt[k] = tmp[k+1];
      end
      cnt_nxt = cnt_new - LEN_W'(1);
    end else begin
      cnt_nxt = cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg.clear) begin
      cnt_r <= '0;
    end else if (acc) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int k = 0; k < MaxPattern; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  `SFR_ASSERT(a_front_cnt_below_plen, cnt_r == '0 || cnt_r < cfg.plen, "pending count reached pattern length")
  `SFR_ASSERT(a_front_push_has_room, cmd_push |-> !q_full, "command pushed into full queue")

endmodule

>>> rtl/sfr_queue.sv
// Short command queue between the front end and the emitter.
`include "stream_find_replace_defines.svh"
module sfr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfr_pkg::sfr_cmd_t push_cmd,
  input  logic              pop,
  output sfr_pkg::sfr_cmd_t head,
  output logic              empty,
  output logic              full
);
  import sfr_pkg::*;

  sfr_cmd_t         data_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == QCntW'(QDepth));
  assign head  = data_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPtrW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      if (push && !pop) begin
        count_r <= count_r + QCntW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) data_r[wr_ptr_r] <= push_cmd;
  end

  `SFR_ASSERT(a_queue_pop_nonempty, pop |-> !empty, "pop from empty queue")
  `SFR_ASSERT(a_queue_count_bound, count_r <= QCntW'(QDepth), "queue count out of range")

endmodule

>>> rtl/sfr_back.sv
// Back end: expands commands into result transactions through an output register.
`include "stream_find_replace_defines.svh"
module sfr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sfr_pkg::sfr_cmd_t head,
  input  logic              q_empty,
  output logic              pop,
  sfr_out_if.source         out_if
);
  import sfr_pkg::*;

  localparam int IdxW = $clog2(MaxPattern > MaxValue ? MaxPattern : MaxValue);

  logic [LEN_W-1:0]  idx_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              byte_valid_r, run_last_r, stream_end_r;
  logic              load, is_final, is_empty;

  assign is_empty = (head.count == '0);
  assign is_final = is_empty || (idx_r == head.count - LEN_W'(1));
  assign load     = !q_empty && (!out_valid_r || out_if.ready);
  assign pop      = load && is_final;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_final ? '0 : idx_r + LEN_W'(1);
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r   <= is_empty ? '0 : head.bytes[BYTE_W*idx_r[IdxW-1:0] +: BYTE_W];
      byte_valid_r <= !is_empty;
      run_last_r   <= is_final;
      stream_end_r <= is_final && head.last;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.out_byte   = out_byte_r;
  assign out_if.byte_valid = byte_valid_r;
  assign out_if.run_last   = run_last_r;
  assign out_if.stream_end = stream_end_r;

  `SFR_ASSERT(a_back_idx_in_range, !q_empty |-> (idx_r == '0 || idx_r < head.count), "emit index past command length")
  `SFR_ASSERT(a_back_idx_idle_zero, q_empty |-> idx_r == '0, "emit index left nonzero with no command")

endmodule

>>> rtl/stream_find_replace.sv
// Top level of the byte-stream find-and-replace block.
//
// Text enters on in_if one byte per transaction (in_byte, in_last marks the
// final byte). Results leave on out_if: each carries out_byte and byte_valid,
// run_last on the last result caused by an input byte, and stream_end on the
// final result of the stream (an empty marker with byte_valid low if nothing
// is left). The APB port holds pattern bytes/length at 0x00/0x08 and value
// bytes/length at 0x10/0x18; write it only while the block is idle.
// A byte is taken every cycle while the two-entry command queue has room.
// The first result of a byte passes through the command queue and then the
// output register; a byte completing a match yields value_length results,
// one per cycle, and a final byte without a match yields up to pattern_length
// results, so the emitter's one result per cycle sets the throughput. When the
// receiver stalls, the output register holds its result, the queue fills and
// in_if.ready drops. Reset clears the registers, the pending count and the
// queue; no clearing pass is needed.
module stream_find_replace (
  input  logic                       clk,
  input  logic                       rst_n,
  sfr_in_if.sink                     in_if,
  sfr_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfr_pkg::CFG_AW-1:0] paddr,
  input  logic [sfr_pkg::WORD_W-1:0] pwdata,
  output logic [sfr_pkg::WORD_W-1:0] prdata,
  output logic                       pready
);
  import sfr_pkg::*;

  sfr_cfg_t cfg;
  sfr_cmd_t cmd, head;
  logic     cmd_push, pop, q_empty, q_full;

  sfr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cfg      (cfg),
    .q_full   (q_full),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  sfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  sfr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_if  (out_if)
  );

endmodule
